@@ design/sdd_pkg.sv @@
// Shared types, constants and the de-whitening mask table for the sonde deframer.
// Depends on nothing; every other design file but sdd_ifs uses it.
package sdd_pkg;

	localparam int PAYLOAD_MAX = 200;
	localparam int MASK_LEN = 64;
	localparam int ROM_DEPTH = 64;
	localparam int ROM_IDX_W = $clog2(ROM_DEPTH);
	localparam int SYNC_BYTES = 8;
	localparam int FILL_W = 4;
	localparam int HDR_LAST_POS = 2;
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 64;

	typedef enum logic [APB_ADDR_W-4:0] {
		REG_SYNC_WORD = 1'b0
	} reg_idx_t;

	typedef enum logic [2:0] {
		PH_HDR  = 3'd0,
		PH_TYPE = 3'd1,
		PH_LEN  = 3'd2,
		PH_CHK1 = 3'd3,
		PH_CHK2 = 3'd4,
		PH_DATA = 3'd5,
		PH_STOP = 3'd6
	} phase_t;

	typedef enum logic [1:0] {
		KIND_FRAME_HDR = 2'd0,
		KIND_BLOCK_HDR = 2'd1,
		KIND_BLOCK_DATA = 2'd2,
		KIND_IGNORED = 2'd3
	} kind_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} beat_t;

	typedef struct packed {
		logic [1:0]  byte_kind;
		logic [7:0]  clear_byte;
		logic [7:0]  payload_index;
		logic [7:0]  block_type;
		logic [7:0]  data_offset;
		logic        block_complete;
		logic [15:0] frame_counter;
		logic        counter_valid;
	} result_t;

	localparam logic [7:0] MASK_ROM [ROM_DEPTH] = '{
		8'h96, 8'h83, 8'h3E, 8'h51, 8'hB1, 8'h49, 8'h08, 8'h98,
		8'h32, 8'h05, 8'h59, 8'h0E, 8'hF9, 8'h44, 8'hC6, 8'h26,
		8'h21, 8'h60, 8'hC2, 8'hEA, 8'h79, 8'h5D, 8'h6D, 8'hA1,
		8'h54, 8'h69, 8'h47, 8'h0C, 8'hDC, 8'hE8, 8'h5C, 8'hF1,
		8'hF7, 8'h76, 8'h82, 8'h7F, 8'h07, 8'h99, 8'hA2, 8'h2C,
		8'h93, 8'h7C, 8'h30, 8'h63, 8'hF5, 8'h10, 8'h2E, 8'h61,
		8'hD0, 8'hBC, 8'hB4, 8'hB6, 8'h06, 8'hAA, 8'hF4, 8'h23,
		8'h78, 8'h6E, 8'h3B, 8'hAE, 8'hBF, 8'h7B, 8'h4C, 8'hC1
	};

endpackage

@@ design/sdd_ifs.sv @@
// Valid/ready channel interfaces for the raw byte input and the result output.
// Depends on nothing; the field widths are fixed here.
interface sdd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface sdd_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  byte_kind;
	logic [7:0]  clear_byte;
	logic [7:0]  payload_index;
	logic [7:0]  block_type;
	logic [7:0]  data_offset;
	logic        block_complete;
	logic [15:0] frame_counter;
	logic        counter_valid;

	modport source (output valid, output byte_kind, output clear_byte, output payload_index,
		output block_type, output data_offset, output block_complete,
		output frame_counter, output counter_valid, input ready);
	modport sink (input valid, input byte_kind, input clear_byte, input payload_index,
		input block_type, input data_offset, input block_complete,
		input frame_counter, input counter_valid, output ready);
endinterface

@@ design/sdd_cfg_regs.sv @@
// APB-style register file holding the 64-bit sync word.
// Depends on sdd_pkg for the address width and register indexes.
module sdd_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [sdd_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [sdd_pkg::APB_DATA_W-1:0] pwdata,
	output logic [sdd_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready,
	output logic [63:0]                    sync_word
);

	logic sel_sync;

	assign sel_sync = (paddr[sdd_pkg::APB_ADDR_W-1:3] == sdd_pkg::REG_SYNC_WORD)
		&& (paddr[2:0] == 3'd0);
	assign pready = 1'b1;
	assign prdata = sel_sync ? sync_word : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_word <= '0;
		end else if (psel && penable && pwrite && pready && sel_sync) begin
			sync_word <= pwdata;
		end
	end

endmodule

@@ design/sdd_parser.sv @@
// Sync hunter, de-whitening and block parser: frame state plus one result per beat.
// Depends on sdd_pkg for the phase codes, mask table and result type.
module sdd_parser (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  sdd_pkg::beat_t   beat,
	input  logic [63:0]      sync_word,
	output logic             hit,
	output sdd_pkg::result_t res
);

	logic [63:0]                 window_q, window_d;
	logic [sdd_pkg::FILL_W-1:0]  fill_q, fill_d;
	logic                        in_frame_q, in_frame_d;
	logic [7:0]                  count_q, count_d;
	sdd_pkg::phase_t             phase_q, phase_d;
	logic [7:0]                  type_q, type_d;
	logic [7:0]                  length_q, length_d;
	logic [7:0]                  dpos_q, dpos_d;
	logic [15:0]                 counter_q, counter_d;
	logic [sdd_pkg::ROM_IDX_W-1:0] midx;
	logic [7:0]                  clr;
	logic                        blk_end;
	logic                        active;

	assign active = in_frame_q && (count_q < 8'(sdd_pkg::PAYLOAD_MAX));
	assign midx = sdd_pkg::ROM_IDX_W'(count_q % sdd_pkg::MASK_LEN);
	assign clr = beat.data_byte ^ sdd_pkg::MASK_ROM[midx];
	assign blk_end = ({1'b0, dpos_q} + 9'd1) >= {1'b0, length_q};

	always_comb begin
		window_d = window_q;
		fill_d = fill_q;
		in_frame_d = in_frame_q;
		count_d = count_q;
		phase_d = phase_q;
		type_d = type_q;
		length_d = length_q;
		dpos_d = dpos_q;
		counter_d = counter_q;
		if (!in_frame_q) begin
			window_d = {window_q[55:0], beat.data_byte};
			if (fill_q < sdd_pkg::FILL_W'(sdd_pkg::SYNC_BYTES)) begin
				fill_d = fill_q + 1'b1;
			end
			if (fill_d >= sdd_pkg::FILL_W'(sdd_pkg::SYNC_BYTES) && window_d == sync_word) begin
				in_frame_d = 1'b1;
				count_d = '0;
				phase_d = sdd_pkg::PH_HDR;
			end
		end else if (active) begin
			count_d = count_q + 1'b1;
			case (phase_q)
				sdd_pkg::PH_HDR: begin
					if (count_q == 8'd1) begin
						counter_d = {counter_q[15:8], clr};
					end else if (count_q == 8'(sdd_pkg::HDR_LAST_POS)) begin
						counter_d = {clr, counter_q[7:0]};
					end
					if (count_q >= 8'(sdd_pkg::HDR_LAST_POS)) begin
						phase_d = sdd_pkg::PH_TYPE;
					end
				end
				sdd_pkg::PH_TYPE: begin
					type_d = clr;
					phase_d = sdd_pkg::PH_LEN;
				end
				sdd_pkg::PH_LEN: begin
					length_d = clr;
					phase_d = (clr == 8'd0) ? sdd_pkg::PH_STOP : sdd_pkg::PH_CHK1;
				end
				sdd_pkg::PH_CHK1: begin
					phase_d = sdd_pkg::PH_CHK2;
				end
				sdd_pkg::PH_CHK2: begin
					dpos_d = '0;
					phase_d = sdd_pkg::PH_DATA;
				end
				sdd_pkg::PH_DATA: begin
					if (blk_end) begin
						dpos_d = '0;
						phase_d = sdd_pkg::PH_TYPE;
					end else begin
						dpos_d = dpos_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
		if (beat.last_byte) begin
			window_d = '0;
			fill_d = '0;
			in_frame_d = 1'b0;
			count_d = '0;
			phase_d = sdd_pkg::PH_HDR;
			type_d = '0;
			length_d = '0;
			dpos_d = '0;
			counter_d = '0;
		end
	end

	always_comb begin
		hit = active;
		res.clear_byte = clr;
		res.payload_index = count_q;
		res.byte_kind = sdd_pkg::KIND_IGNORED;
		res.block_type = '0;
		res.data_offset = '0;
		res.block_complete = 1'b0;
		case (phase_q)
			sdd_pkg::PH_HDR: begin
				res.byte_kind = sdd_pkg::KIND_FRAME_HDR;
			end
			sdd_pkg::PH_TYPE: begin
				res.byte_kind = sdd_pkg::KIND_BLOCK_HDR;
				res.block_type = clr;
			end
			sdd_pkg::PH_LEN, sdd_pkg::PH_CHK1, sdd_pkg::PH_CHK2: begin
				res.byte_kind = sdd_pkg::KIND_BLOCK_HDR;
				res.block_type = type_q;
			end
			sdd_pkg::PH_DATA: begin
				res.byte_kind = sdd_pkg::KIND_BLOCK_DATA;
				res.block_type = type_q;
				res.data_offset = dpos_q;
				res.block_complete = blk_end;
			end
			default: begin
			end
		endcase
		if (count_q >= 8'(sdd_pkg::HDR_LAST_POS)) begin
			res.counter_valid = 1'b1;
			res.frame_counter = (count_q == 8'(sdd_pkg::HDR_LAST_POS))
				? {clr, counter_q[7:0]} : counter_q;
		end else begin
			res.counter_valid = 1'b0;
			res.frame_counter = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			fill_q <= '0;
			in_frame_q <= 1'b0;
			count_q <= '0;
			phase_q <= sdd_pkg::PH_HDR;
			type_q <= '0;
			length_q <= '0;
			dpos_q <= '0;
			counter_q <= '0;
		end else if (advance) begin
			window_q <= window_d;
			fill_q <= fill_d;
			in_frame_q <= in_frame_d;
			count_q <= count_d;
			phase_q <= phase_d;
			type_q <= type_d;
			length_q <= length_d;
			dpos_q <= dpos_d;
			counter_q <= counter_d;
		end
	end

endmodule

@@ design/sonde_frame_dewhiten_deframer_unit.sv @@
// Top level of the sonde frame de-whitening deframer.
// Depends on sdd_pkg, sdd_ifs, sdd_cfg_regs and sdd_parser.
//
// The block takes raw received bytes on byte_in and hunts for the 64-bit sync
// word held in the register at address 0 of the APB port. After sync, each
// payload byte is de-whitened with the mask table and classified as frame
// header, block header, block data or ignored; one result beat per payload
// byte leaves on item_out. Hunting bytes and bytes past the payload cap give
// no result. A byte marked last_byte returns the block to hunting.
//
// An accepted beat is captured in an input register and is processed once the
// output register is free or being emptied; its result is then loaded into the
// output register, from which it is valid on item_out. One beat per cycle is
// sustained while item_out does not stall; the frame state is updated when the
// beat is processed, at the same clock edge that loads its result.
// When item_out stalls, the output register holds its beat, the input register
// holds one more, and byte_in.ready drops until the stall clears.
// Reset clears the sync word, the frame state and both valid flags.
module sonde_frame_dewhiten_deframer_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	sdd_in_if.sink                         byte_in,
	sdd_out_if.source                      item_out,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [sdd_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [sdd_pkg::APB_DATA_W-1:0] pwdata,
	output logic [sdd_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready
);

	logic [63:0]      sync_word;
	sdd_pkg::beat_t   beat_s1;
	logic             valid_s1;
	logic             advance;
	logic             hit;
	sdd_pkg::result_t res;
	sdd_pkg::result_t res_q;
	logic             out_valid_q;

	sdd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.sync_word (sync_word)
	);

	sdd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.beat      (beat_s1),
		.sync_word (sync_word),
		.hit       (hit),
		.res       (res)
	);

	assign advance = valid_s1 && (!out_valid_q || item_out.ready);
	assign byte_in.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_in.valid && byte_in.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_in.valid && byte_in.ready) begin
			beat_s1.data_byte <= byte_in.data_byte;
			beat_s1.last_byte <= byte_in.last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && hit) begin
			out_valid_q <= 1'b1;
		end else if (item_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && hit) begin
			res_q <= res;
		end
	end

	assign item_out.valid = out_valid_q;
	assign item_out.byte_kind = res_q.byte_kind;
	assign item_out.clear_byte = res_q.clear_byte;
	assign item_out.payload_index = res_q.payload_index;
	assign item_out.block_type = res_q.block_type;
	assign item_out.data_offset = res_q.data_offset;
	assign item_out.block_complete = res_q.block_complete;
	assign item_out.frame_counter = res_q.frame_counter;
	assign item_out.counter_valid = res_q.counter_valid;

endmodule

@@ design/sdd_checker.sv @@
// Port-level checks on the deframer result channel, bound to the top level.
// Depends on sdd_pkg for the kind codes and the payload cap.
module sdd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  byte_kind,
	input logic [7:0]  clear_byte,
	input logic [7:0]  payload_index,
	input logic [7:0]  block_type,
	input logic [7:0]  data_offset,
	input logic        block_complete,
	input logic [15:0] frame_counter,
	input logic        counter_valid
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(clear_byte)
			&& $stable(payload_index) && $stable(byte_kind))
		else $error("Stalled result beat changed.");

	a_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> payload_index < 8'(sdd_pkg::PAYLOAD_MAX))
		else $error("Result beat beyond payload cap.");

	a_complete: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && block_complete |-> byte_kind == sdd_pkg::KIND_BLOCK_DATA)
		else $error("Block completion outside block data.");

	a_counter: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !counter_valid |-> frame_counter == 16'd0 && payload_index < 8'd2)
		else $error("Frame counter shown before it is valid.");

	a_header: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && byte_kind == sdd_pkg::KIND_FRAME_HDR
			|-> payload_index <= 8'd2 && block_type == 8'd0 && data_offset == 8'd0)
		else $error("Frame header beat out of place.");

endmodule

bind sonde_frame_dewhiten_deframer_unit sdd_checker u_sdd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (item_out.valid),
	.out_ready      (item_out.ready),
	.byte_kind      (item_out.byte_kind),
	.clear_byte     (item_out.clear_byte),
	.payload_index  (item_out.payload_index),
	.block_type     (item_out.block_type),
	.data_offset    (item_out.data_offset),
	.block_complete (item_out.block_complete),
	.frame_counter  (item_out.frame_counter),
	.counter_valid  (item_out.counter_valid)
);
